>>> src/eftp_pkg.sv
// ----------------------------------------------------------------------------
// eftp_pkg: shared types and constants of the egress flow tuple parser.
// Holds the parse phases, protocol numbers and result classes.
// ----------------------------------------------------------------------------
package eftp_pkg;

  typedef enum logic [3:0] {
    PH_ETH     = 4'd0,
    PH_VLAN    = 4'd1,
    PH_IP4     = 4'd2,
    PH_IP4OPT  = 4'd3,
    PH_IP6     = 4'd4,
    PH_EXTOPT  = 4'd5,
    PH_EXTFRAG = 4'd6,
    PH_L4      = 4'd7,
    PH_TAIL    = 4'd8,
    PH_DONE    = 4'd9
  } phase_e;

  typedef enum logic [2:0] {
    KIND_NONE     = 3'd0,
    KIND_TCP_OPEN = 3'd1,
    KIND_TCP_RST  = 3'd2,
    KIND_TCP_OTH  = 3'd3,
    KIND_UDP      = 3'd4,
    KIND_SCTP     = 3'd5
  } kind_e;

  localparam logic [15:0] ETYPE_VLAN  = 16'h8100;
  localparam logic [15:0] ETYPE_QINQ  = 16'h88A8;
  localparam logic [15:0] ETYPE_IPV4  = 16'h0800;
  localparam logic [15:0] ETYPE_IPV6  = 16'h86DD;

  localparam logic [7:0] PROTO_HOP   = 8'd0;
  localparam logic [7:0] PROTO_TCP   = 8'd6;
  localparam logic [7:0] PROTO_UDP   = 8'd17;
  localparam logic [7:0] PROTO_ROUTE = 8'd43;
  localparam logic [7:0] PROTO_FRAG  = 8'd44;
  localparam logic [7:0] PROTO_DEST  = 8'd60;
  localparam logic [7:0] PROTO_SCTP  = 8'd132;

  localparam logic [15:0] V6_FRAG_OFS_MASK = 16'hFFF8;
  localparam logic [15:0] V4_MF_MASK       = 16'h2000;
  localparam logic [15:0] V4_OFS_MASK      = 16'h1FFF;
  localparam logic [7:0]  TCP_SYN          = 8'h02;
  localparam logic [7:0]  TCP_ACK          = 8'h10;
  localparam logic [7:0]  TCP_RST          = 8'h04;

endpackage

>>> src/egress_flow_tuple_parser.sv
// ----------------------------------------------------------------------------
// egress_flow_tuple_parser
// Byte-serial Ethernet/IP parser that captures the reversed five-tuple.
// ----------------------------------------------------------------------------
// The block takes one frame byte per cycle and never stalls its input while
// the result register is free or being drained, so the sustained rate is one
// item per clock. Each byte updates the registered parse state; on the
// byte marked end_of_frame one result is loaded into the output register,
// which is the only storage between the two sides. A non-final byte gives
// no result. The input stalls only when a finished result is still held and
// the output side stalls too.
module egress_flow_tuple_parser #(
  parameter int MAX_TAGS        = 4,
  parameter int MAX_EXT_HEADERS = 6,
  parameter int COUNT_BITS      = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  pkt_byte_i,
  input  logic        end_of_frame_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  track_kind_o,
  output logic        is_ipv6_o,
  output logic [63:0] key_src_hi_o,
  output logic [63:0] key_src_lo_o,
  output logic [63:0] key_dst_hi_o,
  output logic [63:0] key_dst_lo_o,
  output logic [15:0] key_src_port_o,
  output logic [15:0] key_dst_port_o,
  output logic [7:0]  tcp_flag_bits_o
);

  localparam int TW = $clog2(MAX_TAGS + 2);
  localparam int EW = $clog2(MAX_EXT_HEADERS + 2);
  // Sums reach one bit past the counter plus the largest section (2048).
  localparam int SW = COUNT_BITS + 1;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  // Parse state.
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  eftp_pkg::phase_e      ph_q, ph_d;
  logic [15:0]           etype_q, etype_d;
  logic [TW-1:0]         tags_q, tags_d;
  logic [7:0]            proto_q, proto_d;
  logic [EW-1:0]         exts_q, exts_d;
  logic [COUNT_BITS-1:0] send_q, send_d;
  logic [COUNT_BITS-1:0] sbeg_q, sbeg_d;
  logic [15:0]           frag_q, frag_d;
  logic [63:0]           addr_q [4];
  logic [63:0]           addr_d [4];
  logic [15:0]           port_q [2];
  logic [15:0]           port_d [2];
  logic [7:0]            flag_q, flag_d;
  logic [2:0]            kind_q, kind_d;
  logic [5:0]            ip4len_q, ip4len_d;
  logic                  v6_q, v6_d;

  logic in_acc, out_acc;
  assign in_stall_o = out_valid_o && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_o && !out_stall_i;

  // Per-byte parse step.
  always_comb begin
    logic [COUNT_BITS-1:0] rel;
    logic                  last;
    logic                  op_en;
    eftp_pkg::phase_e      op_ph;
    logic [COUNT_BITS-1:0] op_beg;
    logic [SW-1:0]         op_len;
    logic [SW-1:0]         op_end;
    logic                  disp;
    logic [7:0]            p;
    logic [7:0]            b;
    cnt_d = cnt_q; ph_d = ph_q; etype_d = etype_q; tags_d = tags_q;
    proto_d = proto_q; exts_d = exts_q; send_d = send_q; sbeg_d = sbeg_q;
    frag_d = frag_q; addr_d = addr_q; port_d = port_q; flag_d = flag_q;
    kind_d = kind_q; ip4len_d = ip4len_q; v6_d = v6_q;
    b      = pkt_byte_i;
    rel    = cnt_q - sbeg_q;
    last   = (cnt_q + 1'b1) == send_q;
    op_en  = 1'b0;
    op_ph  = eftp_pkg::PH_DONE;
    op_beg = send_q;
    op_len = '0;
    op_end = '0;
    disp   = 1'b0;
    p      = proto_q;

    if (cnt_q != CNT_MAX) begin
      if (ph_q == eftp_pkg::PH_IP6 || ph_q == eftp_pkg::PH_ETH) begin
        v6_d = (ph_q == eftp_pkg::PH_IP6);
      end
      case (ph_q)
        eftp_pkg::PH_ETH, eftp_pkg::PH_VLAN: begin
          if (rel + 2'd2 == send_q - sbeg_q) begin
            etype_d = {b, 8'h00};
          end else if (last) begin
            etype_d = {etype_q[15:8], b};
          end
          if (last) begin
            if (ph_q == eftp_pkg::PH_VLAN) tags_d = tags_q + 1'b1;
            if (etype_d == eftp_pkg::ETYPE_VLAN || etype_d == eftp_pkg::ETYPE_QINQ) begin
              if (32'(tags_d) >= MAX_TAGS) ph_d = eftp_pkg::PH_DONE;
              else begin
                op_en = 1'b1; op_ph = eftp_pkg::PH_VLAN; op_len = SW'(4);
              end
            end else if (etype_d == eftp_pkg::ETYPE_IPV4) begin
              op_en = 1'b1; op_ph = eftp_pkg::PH_IP4; op_len = SW'(20);
            end else if (etype_d == eftp_pkg::ETYPE_IPV6) begin
              op_en = 1'b1; op_ph = eftp_pkg::PH_IP6; op_len = SW'(40);
            end else begin
              ph_d = eftp_pkg::PH_DONE;
            end
          end
        end
        eftp_pkg::PH_IP4: begin
          if (rel == '0) ip4len_d = {b[3:0], 2'b00};
          else if (rel == COUNT_BITS'(6)) frag_d = {b, 8'h00};
          else if (rel == COUNT_BITS'(7)) frag_d = {frag_q[15:8], b};
          else if (rel == COUNT_BITS'(9)) begin
            proto_d = b; p = b;
          end else if (rel >= COUNT_BITS'(12) && rel < COUNT_BITS'(16))
            addr_d[3] = {addr_q[3][55:0], b};
          else if (rel >= COUNT_BITS'(16) && rel < COUNT_BITS'(20))
            addr_d[1] = {addr_q[1][55:0], b};
          if (last) begin
            if (ip4len_d < 6'd20 ||
                (frag_d & (eftp_pkg::V4_MF_MASK | eftp_pkg::V4_OFS_MASK)) != '0) begin
              ph_d = eftp_pkg::PH_DONE;
            end else if (ip4len_d > 6'd20) begin
              op_en = 1'b1; op_ph = eftp_pkg::PH_IP4OPT;
              op_beg = sbeg_q; op_len = SW'(ip4len_d);
            end else begin
              disp = 1'b1;
            end
          end
        end
        eftp_pkg::PH_IP4OPT: begin
          if (last) disp = 1'b1;
        end
        eftp_pkg::PH_IP6: begin
          if (rel == COUNT_BITS'(6)) begin
            proto_d = b; p = b;
          end else if (rel >= COUNT_BITS'(8) && rel < COUNT_BITS'(16))
            addr_d[2] = {addr_q[2][55:0], b};
          else if (rel >= COUNT_BITS'(16) && rel < COUNT_BITS'(24))
            addr_d[3] = {addr_q[3][55:0], b};
          else if (rel >= COUNT_BITS'(24) && rel < COUNT_BITS'(32))
            addr_d[0] = {addr_q[0][55:0], b};
          else if (rel >= COUNT_BITS'(32) && rel < COUNT_BITS'(40))
            addr_d[1] = {addr_q[1][55:0], b};
          if (last) disp = 1'b1;
        end
        eftp_pkg::PH_EXTOPT: begin
          if (rel == '0) begin
            proto_d = b;
          end else if (rel == COUNT_BITS'(1)) begin
            op_en = 1'b1; op_ph = eftp_pkg::PH_EXTOPT; op_beg = sbeg_q;
            op_len = SW'({({1'b0, b} + 9'd1), 3'b000});
          end else if (last) begin
            disp = 1'b1;
          end
        end
        eftp_pkg::PH_EXTFRAG: begin
          if (rel == '0) begin
            proto_d = b; p = b;
          end else if (rel == COUNT_BITS'(2)) frag_d = {b, 8'h00};
          else if (rel == COUNT_BITS'(3)) frag_d = {frag_q[15:8], b};
          if (last) begin
            if ((frag_d & eftp_pkg::V6_FRAG_OFS_MASK) != '0) ph_d = eftp_pkg::PH_DONE;
            else disp = 1'b1;
          end
        end
        eftp_pkg::PH_L4: begin
          if (rel == '0 || rel == COUNT_BITS'(1))
            port_d[1] = {port_q[1][7:0], b};
          else if (rel == COUNT_BITS'(2) || rel == COUNT_BITS'(3))
            port_d[0] = {port_q[0][7:0], b};
          else if (rel == COUNT_BITS'(13) && proto_q == eftp_pkg::PROTO_TCP)
            flag_d = b;
          if (last) begin
            if (proto_q == eftp_pkg::PROTO_TCP) begin
              if ((flag_d & eftp_pkg::TCP_SYN) != '0 && (flag_d & eftp_pkg::TCP_ACK) == '0)
                kind_d = eftp_pkg::KIND_TCP_OPEN;
              else if ((flag_d & eftp_pkg::TCP_RST) != '0)
                kind_d = eftp_pkg::KIND_TCP_RST;
              else
                kind_d = eftp_pkg::KIND_TCP_OTH;
            end else if (proto_q == eftp_pkg::PROTO_UDP) begin
              kind_d = eftp_pkg::KIND_UDP;
            end else begin
              kind_d = eftp_pkg::KIND_SCTP;
            end
            ph_d = eftp_pkg::PH_TAIL;
          end
        end
        default: ;
      endcase

      // Dispatch on the next protocol number once a header is complete.
      if (disp) begin
        if (p == eftp_pkg::PROTO_TCP) begin
          op_en = 1'b1; op_ph = eftp_pkg::PH_L4; op_len = SW'(20);
        end else if (p == eftp_pkg::PROTO_UDP) begin
          op_en = 1'b1; op_ph = eftp_pkg::PH_L4; op_len = SW'(8);
        end else if (p == eftp_pkg::PROTO_SCTP) begin
          op_en = 1'b1; op_ph = eftp_pkg::PH_L4; op_len = SW'(4);
        end else if (v6_d && (p == eftp_pkg::PROTO_HOP || p == eftp_pkg::PROTO_ROUTE ||
                              p == eftp_pkg::PROTO_DEST || p == eftp_pkg::PROTO_FRAG)) begin
          if (32'(exts_q) >= MAX_EXT_HEADERS) ph_d = eftp_pkg::PH_DONE;
          else begin
            exts_d = exts_q + 1'b1;
            op_en  = 1'b1;
            if (p == eftp_pkg::PROTO_FRAG) begin
              op_ph = eftp_pkg::PH_EXTFRAG; op_len = SW'(8);
            end else begin
              op_ph = eftp_pkg::PH_EXTOPT; op_len = SW'(2);
            end
          end
        end else begin
          ph_d = eftp_pkg::PH_DONE;
        end
      end

      // Open a new section unless it would run past the saturated count.
      op_end = SW'(op_beg) + op_len;
      if (op_en) begin
        if (op_end > SW'(CNT_MAX)) ph_d = eftp_pkg::PH_DONE;
        else begin
          ph_d   = op_ph;
          sbeg_d = op_beg;
          send_d = op_end[COUNT_BITS-1:0];
        end
      end
      cnt_d = cnt_q + 1'b1;
    end
  end

  // Parse state registers; a frame's last byte restores the reset values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; ph_q <= eftp_pkg::PH_ETH; etype_q <= '0; tags_q <= '0;
      proto_q <= '0; exts_q <= '0; send_q <= COUNT_BITS'(14); sbeg_q <= '0;
      frag_q <= '0; flag_q <= '0; kind_q <= '0; ip4len_q <= '0; v6_q <= 1'b0;
      for (int i = 0; i < 4; i++) addr_q[i] <= '0;
      port_q[0] <= '0; port_q[1] <= '0;
    end else if (in_acc) begin
      if (end_of_frame_i) begin
        cnt_q <= '0; ph_q <= eftp_pkg::PH_ETH; etype_q <= '0; tags_q <= '0;
        proto_q <= '0; exts_q <= '0; send_q <= COUNT_BITS'(14); sbeg_q <= '0;
        frag_q <= '0; flag_q <= '0; kind_q <= '0; ip4len_q <= '0; v6_q <= 1'b0;
        for (int i = 0; i < 4; i++) addr_q[i] <= '0;
        port_q[0] <= '0; port_q[1] <= '0;
      end else begin
        cnt_q <= cnt_d; ph_q <= ph_d; etype_q <= etype_d; tags_q <= tags_d;
        proto_q <= proto_d; exts_q <= exts_d; send_q <= send_d; sbeg_q <= sbeg_d;
        frag_q <= frag_d; flag_q <= flag_d; kind_q <= kind_d; ip4len_q <= ip4len_d;
        v6_q <= v6_d; addr_q <= addr_d; port_q <= port_d;
      end
    end
  end

  // Result register.
  logic hit;
  assign hit = (ph_d == eftp_pkg::PH_TAIL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (in_acc && end_of_frame_i) begin
      out_valid_o <= 1'b1;
    end else if (out_acc) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && end_of_frame_i) begin
      track_kind_o    <= hit ? kind_d : eftp_pkg::KIND_NONE;
      is_ipv6_o       <= hit && v6_d;
      key_src_hi_o    <= hit ? addr_d[0] : '0;
      key_src_lo_o    <= hit ? addr_d[1] : '0;
      key_dst_hi_o    <= hit ? addr_d[2] : '0;
      key_dst_lo_o    <= hit ? addr_d[3] : '0;
      key_src_port_o  <= hit ? port_d[0] : '0;
      key_dst_port_o  <= hit ? port_d[1] : '0;
      tcp_flag_bits_o <= hit ? flag_d : '0;
    end
  end

  // Checks on the parser's own logic.
  a_no_accept_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !in_acc) else $error("accepted into full result");
  a_eof_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && end_of_frame_i) |=> out_valid_o) else $error("lost result");
  a_eof_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && end_of_frame_i) |=> (cnt_q == '0 && ph_q == eftp_pkg::PH_ETH))
    else $error("frame state not cleared");
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && track_kind_o == eftp_pkg::KIND_NONE) |->
    (key_src_port_o == '0 && tcp_flag_bits_o == '0 && !is_ipv6_o))
    else $error("class none with payload");

endmodule

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// Testbench for egress_flow_tuple_parser
// Frames built from valid and broken header stacks are sent one byte per item.
// A byte-level parse predictor computes the expected tuple of each frame, and
// every result is checked field by field, mostly under random idling on both sides.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_TAGS   = 4;
  localparam int NUM_EXT    = 6;
  localparam int CNT_TOP    = 65535;
  localparam int IDLE_LIMIT = 2000;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic        v6;
    logic [63:0] src_hi;
    logic [63:0] src_lo;
    logic [63:0] dst_hi;
    logic [63:0] dst_lo;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  flags;
  } flow_tuple_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  pkt_byte_i;
  logic        end_of_frame_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  track_kind_o;
  logic        is_ipv6_o;
  logic [63:0] key_src_hi_o;
  logic [63:0] key_src_lo_o;
  logic [63:0] key_dst_hi_o;
  logic [63:0] key_dst_lo_o;
  logic [15:0] key_src_port_o;
  logic [15:0] key_dst_port_o;
  logic [7:0]  tcp_flag_bits_o;

  egress_flow_tuple_parser DUT (.*);

  // Predictor state for the frame in progress.
  int unsigned      pos_cnt;
  eftp_pkg::phase_e phase;
  logic [15:0]      etype;
  int unsigned      tags;
  logic [7:0]       proto;
  int unsigned      exts;
  int unsigned      sec_end;
  int unsigned      sec_begin;
  logic [15:0]      frag;
  logic [63:0]      addr [4];
  logic [15:0]      ports [2];
  logic [7:0]       flag_byte;
  logic [2:0]       kind_val;
  int unsigned      v4_len;
  logic             v6_seen;

  frame_byte_t pending_bytes[$];
  flow_tuple_t expected_tuples[$];
  int          error_count;
  bit          sender_hold;
  bit          idle_on;
  bit          fill_done;

  task automatic clear_parse();
    pos_cnt = 0; phase = eftp_pkg::PH_ETH; etype = '0; tags = 0; proto = '0; exts = 0;
    sec_end = 14; sec_begin = 0; frag = '0; flag_byte = '0;
    kind_val = eftp_pkg::KIND_NONE;
    v4_len = 0; v6_seen = 1'b0;
    for (int i = 0; i < 4; i++) addr[i] = '0;
    ports[0] = '0;
    ports[1] = '0;
  endtask

  task automatic open_sec(eftp_pkg::phase_e ph, int unsigned start, int unsigned len);
    if (start + len > CNT_TOP) begin
      phase = eftp_pkg::PH_DONE;
    end else begin
      phase = ph;
      sec_begin = start;
      sec_end = start + len;
    end
  endtask

  task automatic pick_l3(int unsigned start);
    if (etype == eftp_pkg::ETYPE_VLAN || etype == eftp_pkg::ETYPE_QINQ) begin
      if (tags >= NUM_TAGS) phase = eftp_pkg::PH_DONE;
      else open_sec(eftp_pkg::PH_VLAN, start, 4);
    end else if (etype == eftp_pkg::ETYPE_IPV4) begin
      open_sec(eftp_pkg::PH_IP4, start, 20);
    end else if (etype == eftp_pkg::ETYPE_IPV6) begin
      open_sec(eftp_pkg::PH_IP6, start, 40);
    end else begin
      phase = eftp_pkg::PH_DONE;
    end
  endtask

  task automatic pick_next(int unsigned start);
    if (proto == eftp_pkg::PROTO_TCP) open_sec(eftp_pkg::PH_L4, start, 20);
    else if (proto == eftp_pkg::PROTO_UDP) open_sec(eftp_pkg::PH_L4, start, 8);
    else if (proto == eftp_pkg::PROTO_SCTP) open_sec(eftp_pkg::PH_L4, start, 4);
    else if (v6_seen && (proto == eftp_pkg::PROTO_HOP || proto == eftp_pkg::PROTO_ROUTE ||
                         proto == eftp_pkg::PROTO_DEST || proto == eftp_pkg::PROTO_FRAG)) begin
      if (exts >= NUM_EXT) begin
        phase = eftp_pkg::PH_DONE;
      end else begin
        exts++;
        if (proto == eftp_pkg::PROTO_FRAG) open_sec(eftp_pkg::PH_EXTFRAG, start, 8);
        else open_sec(eftp_pkg::PH_EXTOPT, start, 2);
      end
    end else begin
      phase = eftp_pkg::PH_DONE;
    end
  endtask

  // Advances the parse by one byte and queues a tuple on the last byte.
  task automatic parse_item(logic [7:0] b, logic eof);
    int unsigned rel;
    bit          last;
    flow_tuple_t t;
    if (pos_cnt < CNT_TOP) begin
      if (phase == eftp_pkg::PH_IP6 || phase == eftp_pkg::PH_ETH)
        v6_seen = (phase == eftp_pkg::PH_IP6);
      rel = pos_cnt - sec_begin;
      last = (pos_cnt + 1 == sec_end);
      case (phase)
        eftp_pkg::PH_ETH, eftp_pkg::PH_VLAN: begin
          if (rel + 2 == sec_end - sec_begin) etype = {b, 8'h00};
          else if (last) etype = etype | 16'(b);
          if (last) begin
            if (phase == eftp_pkg::PH_VLAN) tags++;
            pick_l3(sec_end);
          end
        end
        eftp_pkg::PH_IP4: begin
          if (rel == 0) v4_len = int'(b[3:0]) * 4;
          else if (rel == 6) frag = {b, 8'h00};
          else if (rel == 7) frag = frag | 16'(b);
          else if (rel == 9) proto = b;
          else if (rel >= 12 && rel < 16) addr[3] = {addr[3][55:0], b};
          else if (rel >= 16 && rel < 20) addr[1] = {addr[1][55:0], b};
          if (last) begin
            if (v4_len < 20 ||
                (frag & (eftp_pkg::V4_MF_MASK | eftp_pkg::V4_OFS_MASK)) != 0)
              phase = eftp_pkg::PH_DONE;
            else if (v4_len > 20) open_sec(eftp_pkg::PH_IP4OPT, sec_begin, v4_len);
            else pick_next(sec_end);
          end
        end
        eftp_pkg::PH_IP4OPT: if (last) pick_next(sec_end);
        eftp_pkg::PH_IP6: begin
          if (rel == 6) proto = b;
          else if (rel >= 8 && rel < 16) addr[2] = {addr[2][55:0], b};
          else if (rel >= 16 && rel < 24) addr[3] = {addr[3][55:0], b};
          else if (rel >= 24 && rel < 32) addr[0] = {addr[0][55:0], b};
          else if (rel >= 32 && rel < 40) addr[1] = {addr[1][55:0], b};
          if (last) pick_next(sec_end);
        end
        eftp_pkg::PH_EXTOPT: begin
          if (rel == 0) proto = b;
          else if (rel == 1)
            open_sec(eftp_pkg::PH_EXTOPT, sec_begin, (int'(b) + 1) * 8);
          else if (last) pick_next(sec_end);
        end
        eftp_pkg::PH_EXTFRAG: begin
          if (rel == 0) proto = b;
          else if (rel == 2) frag = {b, 8'h00};
          else if (rel == 3) frag = frag | 16'(b);
          if (last) begin
            if ((frag & eftp_pkg::V6_FRAG_OFS_MASK) != 0) phase = eftp_pkg::PH_DONE;
            else pick_next(sec_end);
          end
        end
        eftp_pkg::PH_L4: begin
          if (rel == 0 || rel == 1) ports[1] = {ports[1][7:0], b};
          else if (rel == 2 || rel == 3) ports[0] = {ports[0][7:0], b};
          else if (rel == 13 && proto == eftp_pkg::PROTO_TCP) flag_byte = b;
          if (last) begin
            if (proto == eftp_pkg::PROTO_TCP) begin
              if ((flag_byte & eftp_pkg::TCP_SYN) != 0 &&
                  (flag_byte & eftp_pkg::TCP_ACK) == 0)
                kind_val = eftp_pkg::KIND_TCP_OPEN;
              else if ((flag_byte & eftp_pkg::TCP_RST) != 0)
                kind_val = eftp_pkg::KIND_TCP_RST;
              else kind_val = eftp_pkg::KIND_TCP_OTH;
            end else if (proto == eftp_pkg::PROTO_UDP) begin
              kind_val = eftp_pkg::KIND_UDP;
            end else begin
              kind_val = eftp_pkg::KIND_SCTP;
            end
            phase = eftp_pkg::PH_TAIL;
          end
        end
        default: ;
      endcase
      pos_cnt++;
    end
    if (eof) begin
      t = '0;
      if (phase == eftp_pkg::PH_TAIL) begin
        t.kind = kind_val; t.v6 = v6_seen;
        t.src_hi = addr[0]; t.src_lo = addr[1]; t.dst_hi = addr[2]; t.dst_lo = addr[3];
        t.src_port = ports[0]; t.dst_port = ports[1]; t.flags = flag_byte;
      end
      expected_tuples.push_back(t);
      clear_parse();
    end
  endtask

  // Frame construction helpers.
  logic [7:0] fb[$];

  task automatic add_rand(int n);
    repeat (n) fb.push_back(8'($urandom));
  endtask

  task automatic add_eth(logic [15:0] et);
    add_rand(12);
    fb.push_back(et[15:8]);
    fb.push_back(et[7:0]);
  endtask

  task automatic add_ip4(logic [7:0] pr, int ihl, logic [15:0] fr);
    fb.push_back({4'h4, 4'(ihl)});
    add_rand(5);
    fb.push_back(fr[15:8]);
    fb.push_back(fr[7:0]);
    fb.push_back(8'($urandom));
    fb.push_back(pr);
    add_rand(10);
    if (ihl > 5) add_rand((ihl - 5) * 4);
  endtask

  task automatic add_ip6(logic [7:0] pr);
    add_rand(6);
    fb.push_back(pr);
    add_rand(33);
  endtask

  task automatic add_ext(logic [7:0] pr, logic [7:0] hdr_len);
    fb.push_back(pr);
    fb.push_back(hdr_len);
    add_rand(int'(hdr_len) * 8 + 6);
  endtask

  task automatic add_frag6(logic [7:0] pr, logic [15:0] ofs);
    fb.push_back(pr);
    fb.push_back(8'($urandom));
    fb.push_back(ofs[15:8]);
    fb.push_back(ofs[7:0]);
    add_rand(4);
  endtask

  task automatic add_l4(logic [7:0] pr, logic [7:0] fl);
    int n;
    n = (pr == eftp_pkg::PROTO_TCP) ? 20 : (pr == eftp_pkg::PROTO_UDP) ? 8 : 4;
    for (int i = 0; i < n; i++) fb.push_back((i == 13) ? fl : 8'($urandom));
  endtask

  // Moves the built frame into the send queue, optionally cut or padded.
  task automatic send_frame(int cut, int pad);
    int n;
    n = fb.size();
    if (cut > 0 && cut < n) n = cut;
    add_rand(pad);
    if (cut <= 0) n = fb.size();
    if (n == 0) n = 1;
    for (int i = 0; i < n; i++) pending_bytes.push_back('{fb[i], i == n - 1});
    fb.delete();
  endtask

  function automatic logic [7:0] rand_l4();
    case ($urandom_range(0, 2))
      0: return eftp_pkg::PROTO_TCP;
      1: return eftp_pkg::PROTO_UDP;
      default: return eftp_pkg::PROTO_SCTP;
    endcase
  endfunction

  function automatic logic [7:0] rand_flags();
    case ($urandom_range(0, 4))
      0: return eftp_pkg::TCP_SYN;
      1: return eftp_pkg::TCP_SYN | eftp_pkg::TCP_ACK;
      2: return eftp_pkg::TCP_RST;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] rand_ext();
    case ($urandom_range(0, 3))
      0: return eftp_pkg::PROTO_HOP;
      1: return eftp_pkg::PROTO_ROUTE;
      2: return eftp_pkg::PROTO_DEST;
      default: return eftp_pkg::PROTO_FRAG;
    endcase
  endfunction

  // One random frame; mostly well formed with random content.
  task automatic random_frame();
    int          ntag;
    int          next;
    int          sel;
    logic [7:0]  l4;
    logic [7:0]  chain [$];
    sel = $urandom_range(0, 99);
    ntag = ($urandom_range(0, 3) == 0) ? $urandom_range(1, NUM_TAGS) : 0;
    l4 = rand_l4();
    add_eth(ntag > 0 ?
            ($urandom_range(0, 1) ? eftp_pkg::ETYPE_VLAN : eftp_pkg::ETYPE_QINQ) :
            ($urandom_range(0, 1) ? eftp_pkg::ETYPE_IPV4 : eftp_pkg::ETYPE_IPV6));
    for (int i = 0; i < ntag; i++) begin
      add_rand(2);
      if (i == ntag - 1) begin
        fb.push_back(8'h08);
        fb.push_back(8'h00);
      end else begin
        fb.push_back(8'h81);
        fb.push_back(8'h00);
      end
    end
    if (ntag > 0 && $urandom_range(0, 1)) begin
      fb[fb.size() - 2] = 8'h86;
      fb[fb.size() - 1] = 8'hDD;
    end
    if (fb[fb.size() - 2] == 8'h08) begin
      add_ip4(l4, ($urandom_range(0, 3) == 0) ? $urandom_range(6, 15) : 5,
              ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'h4000);
    end else begin
      next = ($urandom_range(0, 2) == 0) ? $urandom_range(1, NUM_EXT) : 0;
      for (int i = 0; i < next; i++) chain.push_back(rand_ext());
      add_ip6(next > 0 ? chain[0] : l4);
      for (int i = 0; i < next; i++) begin
        if (chain[i] == eftp_pkg::PROTO_FRAG)
          add_frag6(i + 1 < next ? chain[i + 1] : l4,
                    $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 7)));
        else
          add_ext(i + 1 < next ? chain[i + 1] : l4, 8'($urandom_range(0, 2)));
      end
    end
    add_l4(l4, rand_flags());
    if (sel < 8) send_frame($urandom_range(1, fb.size()), 0);
    else if (sel < 14) begin
      fb.delete();
      add_rand($urandom_range(1, 80));
      send_frame(0, 0);
    end else send_frame(0, $urandom_range(0, 6));
  endtask

  // Clock and reset.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Fills the queue of frame bytes: directed frames, then random ones.
  initial begin
    clear_parse();
    error_count = 0;
    sender_hold = 1'b0;
    idle_on = 1'b1;
    fill_done = 1'b0;
    // TCP classes over IPv4, UDP and SCTP over IPv6, every TCP flag case, extremes of bytes.
    add_eth(eftp_pkg::ETYPE_IPV4); add_ip4(eftp_pkg::PROTO_TCP, 5, 16'h0000);
    add_l4(eftp_pkg::PROTO_TCP, eftp_pkg::TCP_SYN);
    send_frame(0, 0);
    add_eth(eftp_pkg::ETYPE_IPV4); add_ip4(eftp_pkg::PROTO_TCP, 15, 16'h4000);
    add_l4(eftp_pkg::PROTO_TCP, 8'hFF);
    send_frame(0, 3);
    add_eth(eftp_pkg::ETYPE_IPV4); add_ip4(eftp_pkg::PROTO_TCP, 5, 16'h0000);
    add_l4(eftp_pkg::PROTO_TCP, eftp_pkg::TCP_RST);
    send_frame(0, 0);
    add_eth(eftp_pkg::ETYPE_IPV4); add_ip4(eftp_pkg::PROTO_TCP, 5, 16'h0000);
    add_l4(eftp_pkg::PROTO_TCP, 8'h00);
    send_frame(0, 0);
    add_eth(eftp_pkg::ETYPE_IPV6); add_ip6(eftp_pkg::PROTO_UDP);
    add_l4(eftp_pkg::PROTO_UDP, 8'h00);
    send_frame(0, 0);
    add_eth(eftp_pkg::ETYPE_IPV6); add_ip6(eftp_pkg::PROTO_SCTP);
    add_l4(eftp_pkg::PROTO_SCTP, 8'h00);
    send_frame(0, 0);
    for (int i = 0; i < 70; i++) fb.push_back(8'hFF);
    send_frame(0, 0);
    for (int i = 0; i < 70; i++) fb.push_back(8'h00);
    send_frame(0, 0);
    // Maximum tags pass; one tag more is refused.
    add_eth(eftp_pkg::ETYPE_VLAN);
    for (int i = 0; i < NUM_TAGS; i++) begin
      add_rand(2); fb.push_back(i == NUM_TAGS - 1 ? 8'h08 : 8'h88);
      fb.push_back(i == NUM_TAGS - 1 ? 8'h00 : 8'hA8);
    end
    add_ip4(eftp_pkg::PROTO_UDP, 5, 16'h0000); add_l4(eftp_pkg::PROTO_UDP, 8'h00);
    send_frame(0, 0);
    add_eth(eftp_pkg::ETYPE_VLAN);
    for (int i = 0; i <= NUM_TAGS; i++) begin
      add_rand(2); fb.push_back(8'h81); fb.push_back(8'h00);
    end
    add_ip4(eftp_pkg::PROTO_UDP, 5, 16'h0000); add_l4(eftp_pkg::PROTO_UDP, 8'h00);
    send_frame(0, 0);
    // Short header length, fragments, and an extension number over IPv4.
    add_eth(eftp_pkg::ETYPE_IPV4); add_ip4(eftp_pkg::PROTO_UDP, 4, 16'h0000);
    add_l4(eftp_pkg::PROTO_UDP, 0); send_frame(0, 0);
    add_eth(eftp_pkg::ETYPE_IPV4); add_ip4(eftp_pkg::PROTO_UDP, 5, 16'h2000);
    add_l4(eftp_pkg::PROTO_UDP, 0); send_frame(0, 0);
    add_eth(eftp_pkg::ETYPE_IPV4); add_ip4(eftp_pkg::PROTO_UDP, 5, 16'h0001);
    add_l4(eftp_pkg::PROTO_UDP, 0); send_frame(0, 0);
    add_eth(eftp_pkg::ETYPE_IPV4); add_ip4(eftp_pkg::PROTO_HOP, 5, 16'h0000);
    add_l4(eftp_pkg::PROTO_UDP, 0); send_frame(0, 0);
    // Full chain of extension headers, then one too many.
    add_eth(eftp_pkg::ETYPE_IPV6); add_ip6(eftp_pkg::PROTO_HOP);
    add_ext(eftp_pkg::PROTO_ROUTE, 0); add_ext(eftp_pkg::PROTO_DEST, 1);
    add_ext(eftp_pkg::PROTO_FRAG, 0);
    add_frag6(eftp_pkg::PROTO_HOP, 16'h0007); add_ext(eftp_pkg::PROTO_DEST, 2);
    add_ext(eftp_pkg::PROTO_TCP, 0);
    add_l4(eftp_pkg::PROTO_TCP, eftp_pkg::TCP_SYN); send_frame(0, 0);
    add_eth(eftp_pkg::ETYPE_IPV6); add_ip6(eftp_pkg::PROTO_HOP);
    for (int i = 0; i < NUM_EXT; i++) add_ext(eftp_pkg::PROTO_DEST, 0);
    add_l4(eftp_pkg::PROTO_TCP, 0); send_frame(0, 0);
    add_eth(eftp_pkg::ETYPE_IPV6); add_ip6(eftp_pkg::PROTO_FRAG);
    add_frag6(eftp_pkg::PROTO_UDP, 16'h0008);
    add_l4(eftp_pkg::PROTO_UDP, 0); send_frame(0, 0);
    // Truncated inside the TCP and UDP headers, and an unknown ether type.
    add_eth(eftp_pkg::ETYPE_IPV4); add_ip4(eftp_pkg::PROTO_TCP, 5, 0);
    add_l4(eftp_pkg::PROTO_TCP, 0); send_frame(14 + 20 + 19, 0);
    add_eth(eftp_pkg::ETYPE_IPV6); add_ip6(eftp_pkg::PROTO_UDP);
    add_l4(eftp_pkg::PROTO_UDP, 0); send_frame(14 + 40 + 7, 0);
    add_eth(16'h1234); add_ip4(eftp_pkg::PROTO_UDP, 5, 0);
    add_l4(eftp_pkg::PROTO_UDP, 0); send_frame(0, 0);
    fb.push_back(8'h5A); send_frame(0, 0);
    wait (pending_bytes.size() == 0);
    // Random frames; once the sender holds until all results are back.
    for (int f = 0; f < 2; f++) random_frame();
    wait (pending_bytes.size() == 0);
    sender_hold = 1'b1;
    wait (expected_tuples.size() == 0);
    sender_hold = 1'b0;
    idle_on = 1'b0;
    for (int f = 0; f < 3; f++) random_frame();
    wait (pending_bytes.size() == 0);
    idle_on = 1'b1;
    for (int f = 0; f < 1; f++) random_frame();
    fill_done = 1'b1;
  end

  // Driver: presents bytes and holds each one until accepted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i     <= 1'b0;
      pkt_byte_i     <= '0;
      end_of_frame_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        parse_item(pkt_byte_i, end_of_frame_i);
        void'(pending_bytes.pop_front());
      end
      // The head of the queue is now the byte to present next.
      if (!(in_valid_i && in_stall_o)) begin
        if (pending_bytes.size() > 0 && !sender_hold &&
            !(idle_on && $urandom_range(0, 99) < 37)) begin
          in_valid_i     <= 1'b1;
          pkt_byte_i     <= pending_bytes[0].data;
          end_of_frame_i <= pending_bytes[0].last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: random stall and field-by-field comparison of results.
  always @(posedge clk_i or negedge rst_ni) begin
    flow_tuple_t exp_t;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_tuples.size() == 0) begin
          $error("result with no expectation waiting");
          error_count++;
        end else begin
          exp_t = expected_tuples.pop_front();
          if (track_kind_o !== exp_t.kind) begin
            $error("track_kind exp %0d got %0d", exp_t.kind, track_kind_o); error_count++;
          end
          if (is_ipv6_o !== exp_t.v6) begin
            $error("is_ipv6 exp %0d got %0d", exp_t.v6, is_ipv6_o); error_count++;
          end
          if (key_src_hi_o !== exp_t.src_hi) begin
            $error("key_src_hi exp %h got %h", exp_t.src_hi, key_src_hi_o); error_count++;
          end
          if (key_src_lo_o !== exp_t.src_lo) begin
            $error("key_src_lo exp %h got %h", exp_t.src_lo, key_src_lo_o); error_count++;
          end
          if (key_dst_hi_o !== exp_t.dst_hi) begin
            $error("key_dst_hi exp %h got %h", exp_t.dst_hi, key_dst_hi_o); error_count++;
          end
          if (key_dst_lo_o !== exp_t.dst_lo) begin
            $error("key_dst_lo exp %h got %h", exp_t.dst_lo, key_dst_lo_o); error_count++;
          end
          if (key_src_port_o !== exp_t.src_port) begin
            $error("key_src_port exp %h got %h", exp_t.src_port, key_src_port_o);
            error_count++;
          end
          if (key_dst_port_o !== exp_t.dst_port) begin
            $error("key_dst_port exp %h got %h", exp_t.dst_port, key_dst_port_o);
            error_count++;
          end
          if (tcp_flag_bits_o !== exp_t.flags) begin
            $error("tcp_flag_bits exp %h got %h", exp_t.flags, tcp_flag_bits_o);
            error_count++;
          end
        end
      end
      out_stall_i <= idle_on && ($urandom_range(0, 99) < 37);
    end
  end

  // Watchdog and end of run.
  initial begin
    int quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (!fill_done || pending_bytes.size() > 0 || expected_tuples.size() > 0 ||
           in_valid_i) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
    repeat (20) @(posedge clk_i);
    if (error_count == 0 && expected_tuples.size() == 0 && !out_valid_o)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
